>>> rtl/oaht_pkg.sv
package oaht_pkg;

    // Field widths
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 7;
    localparam int SLOT_W = 6;

    // Default table depth
    localparam int SLOTS_DEF = 64;

    // Largest capacity the register can name
    localparam int CAP_REG_MAX = (1 << CAP_W) - 1;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd10;

    // Hash unit: bits of key consumed per cycle
    localparam int DIGIT_W   = 4;
    localparam int DIV_STEPS = KEY_W / DIGIT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Operation kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // Outcome codes
    localparam logic [1:0] OUT_INSERTED  = 2'd0;
    localparam logic [1:0] OUT_DELETED   = 2'd1;
    localparam logic [1:0] OUT_NOT_FOUND = 2'd2;
    localparam logic [1:0] OUT_FULL      = 2'd3;

    // One classified operation waiting for the probe walk
    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CAP_W-1:0] home;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PROBE,
        B_CHECK
    } t_back_state;

endpackage

>>> rtl/oaht_front.sv
module oaht_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [oaht_pkg::CAP_W-1:0] i_cap,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_kind,
    input  logic [oaht_pkg::KEY_W-1:0] i_key,
    input  logic [oaht_pkg::VAL_W-1:0] i_value,
    output logic                       o_push_valid,
    input  logic                       i_push_ready,
    output oaht_pkg::t_job             o_push_job
);

    oaht_pkg::t_front_state r_state, n_state;

    logic [oaht_pkg::STEP_W-1:0] r_step;
    logic [oaht_pkg::KEY_W-1:0]  r_shift;
    logic [oaht_pkg::CAP_W-1:0]  r_rem;
    logic                        r_kind;
    logic [oaht_pkg::KEY_W-1:0]  r_key;
    logic [oaht_pkg::VAL_W-1:0]  r_value;
    logic [oaht_pkg::CAP_W:0]    w_rem;
    logic                        w_accept;
    logic                        w_last_step;

    assign w_accept    = i_valid && o_ready;
    assign w_last_step = (r_step == oaht_pkg::STEP_W'(oaht_pkg::DIV_STEPS - 1));

    // Fold the next digit of the key into the remainder, one bit a step
    always_comb begin
        w_rem = {1'b0, r_rem};
        for (int i = 0; i < oaht_pkg::DIGIT_W; i++) begin
            w_rem = {w_rem[oaht_pkg::CAP_W-1:0], r_shift[oaht_pkg::KEY_W-1-i]};
            if (w_rem >= {1'b0, i_cap}) begin
                w_rem = w_rem - {1'b0, i_cap};
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oaht_pkg::F_IDLE: begin
                if (w_accept) n_state = oaht_pkg::F_DIV;
            end
            oaht_pkg::F_DIV: begin
                if (w_last_step) n_state = oaht_pkg::F_PUSH;
            end
            oaht_pkg::F_PUSH: begin
                if (i_push_ready) n_state = oaht_pkg::F_IDLE;
            end
            default: n_state = oaht_pkg::F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready      = 1'b0;
        o_push_valid = 1'b0;
        unique case (r_state)
            oaht_pkg::F_IDLE: o_ready      = 1'b1;
            oaht_pkg::F_DIV:  o_ready      = 1'b0;
            oaht_pkg::F_PUSH: o_push_valid = 1'b1;
            default: begin
                o_ready      = 1'b0;
                o_push_valid = 1'b0;
            end
        endcase
    end

    assign o_push_job = '{kind: r_kind, key: r_key, value: r_value, home: r_rem};

    // Advance the state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oaht_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the transaction and run the hash
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
            r_shift <= i_key;
            r_rem   <= '0;
            r_step  <= '0;
        end else if (r_state == oaht_pkg::F_DIV) begin
            r_rem   <= w_rem[oaht_pkg::CAP_W-1:0];
            r_shift <= r_shift << oaht_pkg::DIGIT_W;
            r_step  <= r_step + oaht_pkg::STEP_W'(1);
        end
    end

endmodule

>>> rtl/oaht_queue.sv
module oaht_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  oaht_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output oaht_pkg::t_job o_pop_job
);

    oaht_pkg::t_job              r_mem [oaht_pkg::QDEPTH];
    logic [oaht_pkg::QPTR_W-1:0] r_wp;
    logic [oaht_pkg::QPTR_W-1:0] r_rp;
    logic [oaht_pkg::QCNT_W-1:0] r_cnt;
    logic                        w_push;
    logic                        w_pop;

    assign o_push_ready = (r_cnt != oaht_pkg::QCNT_W'(oaht_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_job    = r_mem[r_rp];

    // Track fill level and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == oaht_pkg::QPTR_W'(oaht_pkg::QDEPTH - 1)) ? '0
                        : r_wp + oaht_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == oaht_pkg::QPTR_W'(oaht_pkg::QDEPTH - 1)) ? '0
                        : r_rp + oaht_pkg::QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + oaht_pkg::QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - oaht_pkg::QCNT_W'(1);
            end
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

>>> rtl/oaht_back.sv
module oaht_back #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [oaht_pkg::CAP_W-1:0]  i_cap,
    input  logic                        i_pop_valid,
    output logic                        o_pop_ready,
    input  oaht_pkg::t_job              i_pop_job,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_outcome,
    output logic [oaht_pkg::SLOT_W-1:0] o_slot_index,
    output logic [oaht_pkg::CAP_W-1:0]  o_entries_held,
    output logic                        o_load_high
);

    // Only slots below the largest capacity are ever probed
    localparam int CAP_MAX = (SLOTS < oaht_pkg::CAP_REG_MAX) ? SLOTS : oaht_pkg::CAP_REG_MAX;
    localparam int IW      = $clog2(CAP_MAX);
    localparam logic [oaht_pkg::CAP_W-1:0] CAP_MAX_C = oaht_pkg::CAP_W'(CAP_MAX);

    oaht_pkg::t_back_state r_state, n_state;

    // Slot status: used = not empty, live = occupied
    logic [CAP_MAX-1:0]         r_used;
    logic [CAP_MAX-1:0]         r_live;
    logic [oaht_pkg::KEY_W-1:0] mem_key   [CAP_MAX];
    logic [oaht_pkg::VAL_W-1:0] mem_value [CAP_MAX];
    logic [oaht_pkg::KEY_W-1:0] r_rd_key;

    oaht_pkg::t_job             r_job;
    logic [IW-1:0]              r_idx;
    logic [oaht_pkg::CAP_W-1:0] r_n;
    logic [oaht_pkg::CAP_W-1:0] r_count;
    logic [oaht_pkg::CAP_W-1:0] n_count;

    logic                        r_out_valid;
    logic [1:0]                  r_outcome;
    logic [oaht_pkg::SLOT_W-1:0] r_slot;
    logic [oaht_pkg::CAP_W-1:0]  r_held;
    logic                        r_load;

    logic                        w_pop;
    logic                        w_last;
    logic [oaht_pkg::CAP_W-1:0]  w_next7;
    logic [IW-1:0]               w_idx_next;
    logic                        w_done;
    logic                        w_adv;
    logic                        w_to_check;
    logic                        w_set;
    logic                        w_clr;
    logic [1:0]                  w_outcome;
    logic [oaht_pkg::CAP_W+1:0]  w_cap3;

    assign w_pop   = (r_state == oaht_pkg::B_IDLE) && i_pop_valid && !r_out_valid;
    assign w_last  = (oaht_pkg::CAP_W'(r_n + oaht_pkg::CAP_W'(1)) == i_cap);
    assign w_next7 = oaht_pkg::CAP_W'(r_idx) + oaht_pkg::CAP_W'(1);
    assign w_idx_next = (w_next7 == i_cap) ? '0 : IW'(w_next7);

    // Decide the action at the current probe slot
    always_comb begin
        w_done     = 1'b0;
        w_adv      = 1'b0;
        w_to_check = 1'b0;
        w_set      = 1'b0;
        w_clr      = 1'b0;
        w_outcome  = oaht_pkg::OUT_NOT_FOUND;
        unique case (r_state)
            oaht_pkg::B_IDLE: begin
                w_done = 1'b0;
            end
            oaht_pkg::B_PROBE: begin
                if (r_job.kind == oaht_pkg::KIND_INSERT) begin
                    if (!r_live[r_idx]) begin
                        w_done    = 1'b1;
                        w_set     = 1'b1;
                        w_outcome = oaht_pkg::OUT_INSERTED;
                    end else begin
                        w_adv = 1'b1;
                    end
                end else if (!r_used[r_idx]) begin
                    w_done = 1'b1;
                end else if (r_live[r_idx]) begin
                    w_to_check = 1'b1;
                end else begin
                    w_adv = 1'b1;
                end
            end
            oaht_pkg::B_CHECK: begin
                if (r_rd_key == r_job.key) begin
                    w_done    = 1'b1;
                    w_clr     = 1'b1;
                    w_outcome = oaht_pkg::OUT_DELETED;
                end else begin
                    w_adv = 1'b1;
                end
            end
            default: w_done = 1'b0;
        endcase
        // Probe bound reached without a decision
        if (w_adv && w_last) begin
            w_done    = 1'b1;
            w_outcome = (r_job.kind == oaht_pkg::KIND_INSERT) ? oaht_pkg::OUT_FULL
                        : oaht_pkg::OUT_NOT_FOUND;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oaht_pkg::B_IDLE: begin
                if (w_pop) n_state = oaht_pkg::B_PROBE;
            end
            oaht_pkg::B_PROBE: begin
                if (w_done) n_state = oaht_pkg::B_IDLE;
                else if (w_to_check) n_state = oaht_pkg::B_CHECK;
            end
            oaht_pkg::B_CHECK: begin
                n_state = w_done ? oaht_pkg::B_IDLE : oaht_pkg::B_PROBE;
            end
            default: n_state = oaht_pkg::B_IDLE;
        endcase
    end

    assign o_pop_ready = w_pop;

    // Occupancy after this operation and the three-quarter mark
    always_comb begin
        n_count = r_count;
        if (w_set) begin
            n_count = r_count + oaht_pkg::CAP_W'(1);
        end else if (w_clr && (r_count != '0)) begin
            n_count = r_count - oaht_pkg::CAP_W'(1);
        end
    end

    assign w_cap3 = {2'b00, i_cap} + {1'b0, i_cap, 1'b0};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oaht_pkg::B_IDLE;
            r_used      <= '0;
            r_live      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_set) begin
                r_used[r_idx] <= 1'b1;
                r_live[r_idx] <= 1'b1;
            end
            if (w_clr) begin
                r_live[r_idx] <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job, probe position and result payload
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_job <= i_pop_job;
            r_idx <= IW'(i_pop_job.home);
            r_n   <= '0;
        end else if (w_adv && !w_last) begin
            r_idx <= w_idx_next;
            r_n   <= r_n + oaht_pkg::CAP_W'(1);
        end
        if (w_done) begin
            r_outcome <= w_outcome;
            r_slot    <= (w_set || w_clr) ? oaht_pkg::SLOT_W'(r_idx) : '0;
            r_held    <= n_count;
            r_load    <= ({n_count, 2'b00} >= w_cap3);
        end
    end

    // Key and value store, read data registered
    always_ff @(posedge i_clk) begin
        if (w_set) begin
            mem_key[r_idx]   <= r_job.key;
            mem_value[r_idx] <= r_job.value;
        end
        r_rd_key <= mem_key[r_idx];
    end

    assign o_valid        = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_slot_index   = r_slot;
    assign o_entries_held = r_held;
    assign o_load_high    = r_load;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_MAX_C)
        else $error("occupancy beyond usable slots");

    a_idx_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != oaht_pkg::B_IDLE) |-> (oaht_pkg::CAP_W'(r_idx) < i_cap))
        else $error("probe index outside capacity");

    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !r_out_valid)
        else $error("job taken while a result is still held");

    a_check_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == oaht_pkg::B_CHECK) |-> ($past(r_state == oaht_pkg::B_PROBE)
            && r_live[r_idx]))
        else $error("key compare on a slot that is not occupied");
`endif

endmodule

>>> rtl/open_addressing_hash_table_top.sv
// The front accepts a transaction, hashes it (iterative modulo, 8 steps of 4 key bits)
// and pushes it into the queue; it takes no new transaction until that push. The back
// pops the job and probes slots, with an extra key-compare state for an occupied slot on
// delete; the walk covers at most capacity slots, and long walks can stall the front.
// Reset: synchronous, active low; all slots empty, count zero, capacity 10.
// Slot status clears at once from reset; the key and value store is not cleared.
module open_addressing_hash_table_top #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: capacity_in_use
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // key[31:0], value[63:32]
    input  logic [0:0]  i_s_axis_tuser,   // kind[0]
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // outcome[1:0], slot_index[7:2],
                                          // entries_held[14:8], load_high[15]
);

    localparam int CAP_MAX = (SLOTS < oaht_pkg::CAP_REG_MAX) ? SLOTS : oaht_pkg::CAP_REG_MAX;
    localparam logic [oaht_pkg::CAP_W-1:0] CAP_MAX_C = oaht_pkg::CAP_W'(CAP_MAX);

    logic [oaht_pkg::CAP_W-1:0]  r_cap_reg;
    logic [oaht_pkg::CAP_W-1:0]  w_cap;
    logic                        w_push_valid;
    logic                        w_push_ready;
    oaht_pkg::t_job              w_push_job;
    logic                        w_pop_valid;
    logic                        w_pop_ready;
    oaht_pkg::t_job              w_pop_job;
    logic [1:0]                  w_outcome;
    logic [oaht_pkg::SLOT_W-1:0] w_slot;
    logic [oaht_pkg::CAP_W-1:0]  w_held;
    logic                        w_load;

    // Hold the capacity register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_reg <= oaht_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap_reg <= i_cfg_data;
        end
    end

    // Clamp capacity to one and to the usable slots
    always_comb begin
        if (r_cap_reg == '0) begin
            w_cap = oaht_pkg::CAP_W'(1);
        end else if (r_cap_reg > CAP_MAX_C) begin
            w_cap = CAP_MAX_C;
        end else begin
            w_cap = r_cap_reg;
        end
    end

    oaht_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cap        (w_cap),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_kind       (i_s_axis_tuser[0]),
        .i_key        (i_s_axis_tdata[31:0]),
        .i_value      (i_s_axis_tdata[63:32]),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    oaht_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    oaht_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cap          (w_cap),
        .i_pop_valid    (w_pop_valid),
        .o_pop_ready    (w_pop_ready),
        .i_pop_job      (w_pop_job),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_outcome      (w_outcome),
        .o_slot_index   (w_slot),
        .o_entries_held (w_held),
        .o_load_high    (w_load)
    );

    assign o_m_axis_tdata = {w_load, w_held, w_slot, w_outcome};

endmodule

>>> tb/open_addressing_hash_table_top_tb.sv
`timescale 1ns / 100ps

module open_addressing_hash_table_top_tb;

    localparam int TABLE_SLOTS     = oaht_pkg::SLOTS_DEF;
    // Even with the slowest probe walks and stalls on both sides, the ~700 items
    // stay well under this limit.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 200;
    localparam int IDLE_PCT        = 30;
    localparam int KEY_POOL_MAX    = 32;
    localparam int REPORT_MAX      = 10;

    typedef enum logic [1:0] {
        SLOT_EMPTY    = 2'd0,
        SLOT_DELETED  = 2'd1,
        SLOT_OCCUPIED = 2'd2
    } t_slot_state;

    typedef struct packed {
        logic                       kind;
        logic [oaht_pkg::KEY_W-1:0] key;
        logic [oaht_pkg::VAL_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic [1:0]                  outcome;
        logic [oaht_pkg::SLOT_W-1:0] slot;
        logic [oaht_pkg::CAP_W-1:0]  held;
        logic                        load_high;
    } t_answer;

    // Clock, reset and block ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [63:0] in_data   = '0;
    logic [0:0]  in_user   = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [15:0] res_data;

    // Predicted table contents and capacity register
    t_slot_state                tbl_state [TABLE_SLOTS];
    logic [oaht_pkg::KEY_W-1:0] tbl_key   [TABLE_SLOTS];
    int unsigned                tbl_count;
    logic [oaht_pkg::CAP_W-1:0] cap_reg = oaht_pkg::CAP_RESET;

    // Operations waiting to be sent, and answers waiting to come back
    t_request                   send_queue[$];
    t_answer                    pending_answers[$];
    logic [oaht_pkg::KEY_W-1:0] key_pool[$];

    // Run control and statistics
    bit          in_taken      = 1'b0;
    bit          steady_flow   = 1'b0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          cycle_count   = 0;
    int          mismatch_count = 0;
    int          ops_sent      = 0;
    int          answers_seen  = 0;
    int          outcome_seen [4];
    int          cap_writes    = 0;

    open_addressing_hash_table_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Zero reads as one slot, anything beyond the table saturates
    function automatic int unsigned effective_slots(input logic [oaht_pkg::CAP_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > TABLE_SLOTS)
            return TABLE_SLOTS;
        return 32'(cap);
    endfunction

    // Apply one insert or delete to the predicted table and return its answer
    function automatic t_answer apply_table_op(input t_request req);
        int unsigned cap;
        int unsigned pos;
        bit          done;
        t_answer     ans;
        cap         = effective_slots(cap_reg);
        pos         = req.key % cap;
        done        = 1'b0;
        ans.outcome = (req.kind == oaht_pkg::KIND_INSERT) ? oaht_pkg::OUT_FULL
                      : oaht_pkg::OUT_NOT_FOUND;
        ans.slot    = '0;
        for (int n = 0; n < cap && !done; n++) begin
            if (req.kind == oaht_pkg::KIND_INSERT) begin
                // any non-occupied slot takes the key, tombstones included
                if (tbl_state[pos] != SLOT_OCCUPIED) begin
                    tbl_state[pos] = SLOT_OCCUPIED;
                    tbl_key[pos]   = req.key;
                    tbl_count++;
                    ans.outcome    = oaht_pkg::OUT_INSERTED;
                    ans.slot       = pos[oaht_pkg::SLOT_W-1:0];
                    done           = 1'b1;
                end
            end else if (tbl_state[pos] == SLOT_EMPTY) begin
                done = 1'b1;
            end else if (tbl_state[pos] == SLOT_OCCUPIED && tbl_key[pos] == req.key) begin
                tbl_state[pos] = SLOT_DELETED;
                if (tbl_count > 0)
                    tbl_count--;
                ans.outcome = oaht_pkg::OUT_DELETED;
                ans.slot    = pos[oaht_pkg::SLOT_W-1:0];
                done        = 1'b1;
            end
            if (!done)
                pos = (pos + 1 == cap) ? 0 : pos + 1;
        end
        ans.held      = tbl_count[oaht_pkg::CAP_W-1:0];
        ans.load_high = (4 * tbl_count >= 3 * cap);
        return ans;
    endfunction

    // Driver: present the next pending operation, idling at random
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (send_queue.size() > 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                in_valid <= 1'b1;
                in_data  <= {send_queue[0].value, send_queue[0].key};
                in_user  <= send_queue[0].kind;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Accept operations and predict their answers
    always @(posedge clk) begin
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            pending_answers.push_back(apply_table_op(send_queue[0]));
            send_queue.pop_front();
            ops_sent++;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_OFF_CYCLES;
            res_ready   <= 1'b0;
        end else begin
            res_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk) begin : check_results
        t_answer got;
        t_answer want;
        if (rst_n && res_valid && res_ready) begin
            got.outcome   = res_data[1:0];
            got.slot      = res_data[7:2];
            got.held      = res_data[14:8];
            got.load_high = res_data[15];
            answers_seen++;
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: outcome %0d slot %0d held %0d load_high %0b",
                             got.outcome, got.slot, got.held, got.load_high);
            end else begin
                want = pending_answers.pop_front();
                outcome_seen[want.outcome]++;
                if (got !== want) begin
                    mismatch_count++;
                    // fields shown as outcome/slot/held/load_high
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.outcome, want.slot, want.held, want.load_high,
                                 got.outcome, got.slot, got.held, got.load_high);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("open_addressing_hash_table_top test failed");
            $finish;
        end
    end

    task automatic queue_op(input logic kind, input logic [oaht_pkg::KEY_W-1:0] key,
                            input logic [oaht_pkg::VAL_W-1:0] value);
        t_request req;
        req.kind  = kind;
        req.key   = key;
        req.value = value;
        send_queue.push_back(req);
    endtask

    // Hold until every operation is sent and every answer has come back
    task automatic wait_idle();
        while (send_queue.size() != 0 || pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [oaht_pkg::CAP_W-1:0] cap);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cap_reg = cap;
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random operations: mostly reused or colliding keys so probes run long
    task automatic run_random_phase(input logic [oaht_pkg::CAP_W-1:0] cap, input int count,
                                    input int insert_pct, input bit no_idle,
                                    input bit hold_off);
        int unsigned                slots;
        int unsigned                pick;
        logic                       kind;
        logic [oaht_pkg::KEY_W-1:0] key;
        write_capacity(cap);
        steady_flow = no_idle;
        slots       = effective_slots(cap);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            kind = ($urandom_range(99) < insert_pct) ? oaht_pkg::KIND_INSERT
                   : oaht_pkg::KIND_DELETE;
            if (pick < 40 && key_pool.size() > 0) begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            end else if (pick < 85) begin
                key = $urandom();
                key = key - (key % slots) + $urandom_range(2);
            end else begin
                key = $urandom();
            end
            if (kind == oaht_pkg::KIND_INSERT) begin
                key_pool.push_back(key);
                if (key_pool.size() > KEY_POOL_MAX)
                    key_pool.pop_front();
            end
            queue_op(kind, key, $urandom());
        end
        if (hold_off)
            hold_requests++;
        wait_idle();
        steady_flow = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_state[i] = SLOT_EMPTY;
            tbl_key[i]   = '0;
        end
        tbl_count = 0;
        for (int i = 0; i < 4; i++)
            outcome_seen[i] = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Capacity after reset: collisions, duplicates, tombstone skip and reuse
        queue_op(oaht_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        queue_op(oaht_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(oaht_pkg::KIND_INSERT, 32'd10, 32'h0000_0001);
        queue_op(oaht_pkg::KIND_INSERT, 32'd10, 32'h0000_0002);
        queue_op(oaht_pkg::KIND_DELETE, 32'd10, 32'hA5A5_A5A5);
        queue_op(oaht_pkg::KIND_DELETE, 32'd10, 32'h0000_0000);
        queue_op(oaht_pkg::KIND_DELETE, 32'd10, 32'h0000_0000);
        queue_op(oaht_pkg::KIND_INSERT, 32'd30, 32'h1234_5678);
        queue_op(oaht_pkg::KIND_DELETE, 32'd5, 32'h0000_0000);

        // Capacity zero acts as one slot: full table and exhausted probe bound
        write_capacity(7'd0);
        queue_op(oaht_pkg::KIND_INSERT, 32'd7, 32'h8000_0000);
        queue_op(oaht_pkg::KIND_DELETE, 32'd3, 32'h0000_0000);
        queue_op(oaht_pkg::KIND_DELETE, 32'd0, 32'h0000_0000);
        queue_op(oaht_pkg::KIND_INSERT, 32'd7, 32'h7FFF_FFFF);

        // Oversized capacity saturates: probe wraps from the top slot
        write_capacity(7'd127);
        queue_op(oaht_pkg::KIND_INSERT, 32'd63, 32'hDEAD_BEEF);
        queue_op(oaht_pkg::KIND_INSERT, 32'd127, 32'h0F0F_0F0F);
        queue_op(oaht_pkg::KIND_DELETE, 32'd127, 32'h0000_0000);
        queue_op(oaht_pkg::KIND_DELETE, 32'h8000_0000, 32'h0000_0000);

        run_random_phase(7'd64, 150, 70, 1'b0, 1'b1);
        run_random_phase(7'd1,   40, 50, 1'b0, 1'b0);
        run_random_phase(7'd3,   60, 60, 1'b0, 1'b0);
        run_random_phase(7'd64, 150, 80, 1'b1, 1'b0);
        run_random_phase(7'd17, 100, 50, 1'b0, 1'b1);
        run_random_phase(7'd10, 150, 45, 1'b0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d operations, %0d results over %0d capacity writes",
                 ops_sent, answers_seen, cap_writes);
        $display("inserted %0d, deleted %0d, not found %0d, full %0d; %0d mismatches",
                 outcome_seen[oaht_pkg::OUT_INSERTED], outcome_seen[oaht_pkg::OUT_DELETED],
                 outcome_seen[oaht_pkg::OUT_NOT_FOUND], outcome_seen[oaht_pkg::OUT_FULL],
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("open_addressing_hash_table_top test passed");
        end else begin
            $display("open_addressing_hash_table_top test failed");
        end
        $finish;
    end

endmodule
